// ===== src/four_channel_lamp_test_sweep_defines.svh =====
// Assertion macros for the lamp test sweep checker.
// No dependencies; included by the checker file.
`ifndef FOUR_CHANNEL_LAMP_TEST_SWEEP_DEFINES_SVH
`define FOUR_CHANNEL_LAMP_TEST_SWEEP_DEFINES_SVH

// next-cycle implication, masked while reset is asserted
`define FCLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also covers the reset cycles
`define FCLS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/fcls_pkg.sv =====
// Shared constants, types and the microcode table of the lamp test sweep.
// No dependencies.
package fcls_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int LEVEL_WIDTH_DEF  = 7;

    localparam int MAX_W      = 7;
    localparam int TOP_W      = 32;
    localparam int CMP_W      = 32;
    localparam int CHAN_W     = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 3;

    localparam int CURVE_DIV   = 5000;
    localparam int REM_W       = 13;   // holds CURVE_DIV - 1
    localparam int DIV_RADIX_B = 4;    // quotient bits per divider step

    localparam int MAX_LEVEL_RST = 99;
    localparam int TIMER_TOP_RST = 1000;
    localparam int START_LEVEL   = 2;
    localparam int BOTTOM_LEVEL  = 1;
    localparam int CFG_CHANNELS  = 4;  // channels that have a writable max-level register

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LEVEL0 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TIMER_TOP  = 3'd4;

    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] PC_WAIT   = 3'd0;
    localparam logic [PC_W-1:0] PC_SQUARE = 3'd1;
    localparam logic [PC_W-1:0] PC_MULT   = 3'd2;
    localparam logic [PC_W-1:0] PC_DIV    = 3'd3;
    localparam logic [PC_W-1:0] PC_FINISH = 3'd4;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_SQUARE,
        OP_MULT,
        OP_DIV,
        OP_FINISH
    } op_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_NO_GO,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            to_start;
    } ctrl_t;

    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        case (pc)
            PC_WAIT:   w = '{op: OP_WAIT,   cond: COND_NO_GO,    target: PC_WAIT,
                             to_start: 1'b0};
            PC_SQUARE: w = '{op: OP_SQUARE, cond: COND_NONE,     target: PC_WAIT,
                             to_start: 1'b0};
            PC_MULT:   w = '{op: OP_MULT,   cond: COND_NONE,     target: PC_WAIT,
                             to_start: 1'b0};
            PC_DIV:    w = '{op: OP_DIV,    cond: COND_DIV_MORE, target: PC_DIV,
                             to_start: 1'b0};
            PC_FINISH: w = '{op: OP_FINISH, cond: COND_OUT_BUSY, target: PC_FINISH,
                             to_start: 1'b1};
            default:   w = '{op: OP_WAIT,   cond: COND_NONE,     target: PC_WAIT,
                             to_start: 1'b1};
        endcase
        return w;
    endfunction

endpackage

// ===== src/four_channel_lamp_test_sweep.sv =====
// Lamp self-test sweep: microcoded sequencer over a squarer, a multiplier
// and a radix-16 divide-by-constant unit. Depends on fcls_pkg.
//
//  channel   dir  payload                                  handshake
//  s_        in   tdata[0] test_on                         tvalid/tready
//  m_        out  tdata compare_value, tuser chan/finished tvalid/tready
//  cfg_      in   addr = register index, wdata             wr_en, no wait
//
// An item with test_on set for an unfinished channel has its result
// registered after the square, multiply, 12 divider steps of 4
// quotient bits each and finish steps that follow its acceptance.
// Other items are taken in the wait step and give no result.
// The next item is accepted once the result sits in the output register;
// a stalled output only holds the finish step. Reset (aresetn low, sync)
// returns the sequencer to the wait step and restores register defaults.
module four_channel_lamp_test_sweep
    import fcls_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int LEVEL_WIDTH  = LEVEL_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [0] test_on
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [31:0] compare_value
    output logic [M_TUSER_W-1:0]  m_tuser,   // [1:0] channel, [2] test_finished
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CH_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SQ_W       = 2 * LEVEL_WIDTH;
    localparam int PROD_W     = TOP_W + SQ_W;
    localparam int DIV_STEPS  = (PROD_W + DIV_RADIX_B - 1) / DIV_RADIX_B;
    localparam int DIV_W      = DIV_STEPS * DIV_RADIX_B;
    localparam int DCNT_W     = $clog2(DIV_STEPS);
    localparam logic [REM_W:0]       DIVISOR = (REM_W + 1)'(CURVE_DIV);
    localparam logic [CH_W-1:0]      LAST_CH = CH_W'(NUM_CHANNELS - 1);
    localparam logic [DCNT_W-1:0]    LAST_DIV = DCNT_W'(DIV_STEPS - 1);
    localparam logic [LEVEL_WIDTH-1:0] BOTTOM = LEVEL_WIDTH'(BOTTOM_LEVEL);

    // sequencer
    logic [PC_W-1:0] pc_reg, pc_next;
    ctrl_t           ctrl;

    // configuration
    logic [MAX_W-1:0] max_level_reg [NUM_CHANNELS];
    logic [TOP_W-1:0] timer_top_reg;

    // channel state
    logic [LEVEL_WIDTH-1:0] level_reg [NUM_CHANNELS];
    logic [LEVEL_WIDTH-1:0] level_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] falling_reg, falling_next;
    logic [NUM_CHANNELS-1:0] done_reg, done_next;
    logic [CH_W-1:0]         turn_reg, turn_next;

    // datapath
    logic [CH_W-1:0]        cur_reg, cur_next;
    logic [LEVEL_WIDTH-1:0] lvl_reg, lvl_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [DIV_W-1:0]       div_reg, div_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [DCNT_W-1:0]      dcnt_reg, dcnt_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [CMP_W-1:0]  cmp_reg, cmp_next;
    logic [CHAN_W-1:0] chan_reg, chan_next;
    logic              fin_reg, fin_next;

    logic go, out_free, take, jump;
    logic [PROD_W-1:0] prod;
    logic [REM_W:0]    r;
    logic [DIV_W-1:0]  d;
    logic [DIV_W-1:0]  qm1;
    logic [DIV_W-1:0]  qhalf;
    logic [CMP_W-1:0]  cmp_val;
    logic [LEVEL_WIDTH:0] lvl_p1;
    logic              turn_now, at_bottom, fall_new;
    logic [NUM_CHANNELS-1:0] done_upd;

    assign ctrl     = ucode(pc_reg);
    assign s_tready = (ctrl.op == OP_WAIT);
    assign take     = s_tvalid && s_tready;
    assign go       = take && s_tdata[0] && !done_reg[turn_reg];
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = cmp_reg;
    assign m_tuser  = {fin_reg, chan_reg};

    always_comb begin
        case (ctrl.cond)
            COND_NONE:     jump = 1'b0;
            COND_NO_GO:    jump = !go;
            COND_DIV_MORE: jump = (dcnt_reg != LAST_DIV);
            COND_OUT_BUSY: jump = !out_free;
            default:       jump = 1'b0;
        endcase
        if (jump) begin
            pc_next = ctrl.target;
        end else if (ctrl.to_start) begin
            pc_next = PC_WAIT;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    // divider step: DIV_RADIX_B restoring steps on the remainder
    always_comb begin
        r = {1'b0, rem_reg};
        d = div_reg;
        for (int k = 0; k < DIV_RADIX_B; k++) begin
            r = {r[REM_W-1:0], d[DIV_W-1]};
            d = {d[DIV_W-2:0], 1'b0};
            if (r >= DIVISOR) begin
                r    = r - DIVISOR;
                d[0] = 1'b1;
            end
        end
    end

    // compare = (q - 1) >> 1, zero for q == 0, saturated to 32 bits
    always_comb begin
        qm1   = div_reg - 1'b1;
        qhalf = qm1 >> 1;
        if (div_reg == '0) begin
            cmp_val = '0;
        end else if (|qhalf[DIV_W-1:CMP_W]) begin
            cmp_val = '1;
        end else begin
            cmp_val = qhalf[CMP_W-1:0];
        end
    end

    // level stepping for the current channel
    always_comb begin
        lvl_p1    = {1'b0, lvl_reg} + 1'b1;
        turn_now  = lvl_p1 >= (LEVEL_WIDTH + 1)'(max_level_reg[cur_reg]);
        at_bottom = lvl_reg <= BOTTOM;
        fall_new  = at_bottom ? 1'b0 : (falling_reg[cur_reg] || turn_now);
        done_upd  = done_reg;
        if (at_bottom) begin
            done_upd[cur_reg] = 1'b1;
        end
    end

    assign prod = timer_top_reg * sq_reg;

    always_comb begin
        cur_next     = cur_reg;
        lvl_next     = lvl_reg;
        sq_next      = sq_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        dcnt_next    = dcnt_reg;
        turn_next    = turn_reg;
        falling_next = falling_reg;
        done_next    = done_reg;
        level_next   = level_reg;
        cmp_next     = cmp_reg;
        chan_next    = chan_reg;
        fin_next     = fin_reg;
        m_valid_next = m_valid_reg && !m_tready;
        case (ctrl.op)
            OP_WAIT: begin
                if (take && s_tdata[0]) begin
                    turn_next = (turn_reg == LAST_CH) ? '0 : turn_reg + 1'b1;
                    cur_next  = turn_reg;
                    lvl_next  = level_reg[turn_reg];
                end
            end
            OP_SQUARE: begin
                sq_next = lvl_reg * lvl_reg;
            end
            OP_MULT: begin
                div_next  = DIV_W'(prod);
                rem_next  = '0;
                dcnt_next = '0;
            end
            OP_DIV: begin
                div_next  = d;
                rem_next  = r[REM_W-1:0];
                dcnt_next = dcnt_reg + 1'b1;
            end
            OP_FINISH: begin
                if (out_free) begin
                    falling_next[cur_reg] = fall_new;
                    level_next[cur_reg]   = fall_new ? lvl_reg - 1'b1 : lvl_reg + 1'b1;
                    fin_next     = &done_upd;
                    done_next    = (&done_upd) ? '0 : done_upd;
                    cmp_next     = cmp_val;
                    chan_next    = CHAN_W'(cur_reg);
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= PC_WAIT;
            m_valid_reg   <= 1'b0;
            turn_reg      <= '0;
            falling_reg   <= '0;
            done_reg      <= '0;
            timer_top_reg <= TOP_W'(TIMER_TOP_RST);
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                level_reg[i]     <= LEVEL_WIDTH'(START_LEVEL);
                max_level_reg[i] <= MAX_W'(MAX_LEVEL_RST);
            end
        end else begin
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
            turn_reg    <= turn_next;
            falling_reg <= falling_next;
            done_reg    <= done_next;
            level_reg   <= level_next;
            if (cfg_wr_en && cfg_addr == REG_TIMER_TOP) begin
                timer_top_reg <= cfg_wdata[TOP_W-1:0];
            end
            // only the first four channels have a writable max-level register
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (i < CFG_CHANNELS && cfg_wr_en &&
                    cfg_addr == REG_MAX_LEVEL0 + CFG_ADDR_W'(i)) begin
                    max_level_reg[i] <= cfg_wdata[MAX_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        lvl_reg  <= lvl_next;
        sq_reg   <= sq_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        dcnt_reg <= dcnt_next;
        cmp_reg  <= cmp_next;
        chan_reg <= chan_next;
        fin_reg  <= fin_next;
    end

endmodule

// ===== src/fcls_chk.sv =====
// Port-level checker for the lamp test sweep, bound to the top level.
// Depends on fcls_pkg and four_channel_lamp_test_sweep_defines.svh.
`include "four_channel_lamp_test_sweep_defines.svh"

module fcls_chk
    import fcls_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,   // [0] test_on
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,   // [31:0] compare_value
    input logic [M_TUSER_W-1:0] m_tuser    // [1:0] channel, [2] test_finished
);

    // a stalled result stays offered
    `FCLS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // a stalled result keeps its payload
    `FCLS_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result payload changed while stalled")

    // a result is never ready in the cycle after its item is taken
    `FCLS_ASSERT_NEXT(a_no_fast_result, aclk, aresetn, s_tvalid && s_tready && s_tdata[0] && !m_tvalid, !m_tvalid, "result appeared too early")

    // reset leaves the sequencer waiting with an empty output
    `FCLS_ASSERT_NEXT_ALWAYS(a_reset_idle, aclk, !aresetn, s_tready && !m_tvalid, "not idle after reset")

endmodule

bind four_channel_lamp_test_sweep fcls_chk u_fcls_chk (.*);
